### rtl/core/owscr_pkg.sv
`timescale 1ns / 1ps

package owscr_pkg;

  localparam int ScratchpadBytesDef = 8;
  localparam int PosW = 4;

  typedef logic [7:0] byte_t;
  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    logic signed [15:0] temperature_sixteenths;
    logic               crc_valid;
    byte_t              computed_crc;
  } result_t;

  localparam byte_t CrcLoNib [16] = '{
    8'h00, 8'h5E, 8'hBC, 8'hE2, 8'h61, 8'h3F, 8'hDD, 8'h83,
    8'hC2, 8'h9C, 8'h7E, 8'h20, 8'hA3, 8'hFD, 8'h1F, 8'h41
  };

  localparam byte_t CrcHiNib [16] = '{
    8'h00, 8'h9D, 8'h23, 8'hBE, 8'h46, 8'hDB, 8'h65, 8'hF8,
    8'h8C, 8'h11, 8'hAF, 8'h32, 8'hCA, 8'h57, 8'hE9, 8'h74
  };

endpackage

### rtl/core/onewire_scratchpad_crc_temperature.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid/in_ready    data_byte, frame_start
// out      out_valid/out_ready  temperature_sixteenths, crc_valid, computed_crc
// A byte per cycle while in_ready is high; its CRC and count settle that cycle.
// A result appears in the output buffer the cycle after the CRC byte is taken.
// The two-entry output buffer lets bytes keep flowing while one result waits;
// in_ready drops only while both entries are held.
// Reset (rst, synchronous) clears count, CRC, temperature bytes and the buffer.

module onewire_scratchpad_crc_temperature #(
  parameter int SCRATCHPAD_BYTES = owscr_pkg::ScratchpadBytesDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  temperature_sixteenths,
  output logic                crc_valid,
  output logic [7:0]          computed_crc
);
  import owscr_pkg::*;

  localparam pos_t LastPos = PosW'(SCRATCHPAD_BYTES);

  pos_t    byte_position;
  byte_t   running_crc;
  byte_t   temp_low_byte;
  byte_t   temp_high_byte;
  pos_t    pos_eff;
  byte_t   crc_eff;
  byte_t   crc_folded;
  logic    is_check;
  logic    in_fire;
  logic    buf_full;
  logic    crc_ok;
  result_t result;
  result_t out_data;

  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    pos_eff  = frame_start ? '0 : byte_position;
    crc_eff  = frame_start ? '0 : running_crc;
    is_check = (pos_eff == LastPos);
    crc_ok   = (crc_eff == data_byte);
    result.temperature_sixteenths = crc_ok ? $signed({temp_high_byte, temp_low_byte})
                                           : 16'sd0;
    result.crc_valid    = crc_ok;
    result.computed_crc = crc_eff;
  end

  owscr_crc_fold u_fold (
    .crc_in  (crc_eff),
    .data_in (data_byte),
    .crc_out (crc_folded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_crc    <= '0;
      temp_low_byte  <= '0;
      temp_high_byte <= '0;
    end else if (in_fire) begin
      if (is_check) begin
        byte_position <= '0;
        running_crc   <= '0;
      end else begin
        byte_position <= pos_eff + pos_t'(1);
        running_crc   <= crc_folded;
        if (pos_eff == pos_t'(0)) begin
          temp_low_byte <= data_byte;
        end
        if (pos_eff == pos_t'(1)) begin
          temp_high_byte <= data_byte;
        end
      end
    end
  end

  owscr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && is_check),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign temperature_sixteenths = out_data.temperature_sixteenths;
  assign crc_valid              = out_data.crc_valid;
  assign computed_crc           = out_data.computed_crc;

  a_pos_range: assert property (@(posedge clk) disable iff (rst) byte_position <= LastPos)
    else $error("byte position past CRC byte");
  a_check_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_check) |=> (byte_position == pos_t'(0)) && (running_crc == 8'h00))
    else $error("count or CRC not restarted after CRC byte");
  a_start_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_start) |=> (byte_position == pos_t'(1)))
    else $error("frame start did not restart the count");

endmodule

### rtl/core/owscr_crc_fold.sv
`timescale 1ns / 1ps

module owscr_crc_fold (
  input  owscr_pkg::byte_t crc_in,
  input  owscr_pkg::byte_t data_in,
  output owscr_pkg::byte_t crc_out
);
  import owscr_pkg::*;

  byte_t mix;

  always_comb begin
    mix = crc_in ^ data_in;
    crc_out = CrcLoNib[mix[3:0]] ^ CrcHiNib[mix[7:4]];
  end

endmodule

### rtl/core/owscr_out_buf.sv
`timescale 1ns / 1ps

module owscr_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  owscr_pkg::result_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output owscr_pkg::result_t  out_data
);
  import owscr_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    slot0;
  result_t    slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      slot0 <= push_data;
    end else if (pop && (count == 2'd2)) begin
      slot0 <= slot1;
    end
    if (push && (count == 2'd1) && !pop) begin
      slot1 <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("result pushed into full buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("buffer count out of range");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !out_ready) |=> full)
    else $error("full buffer lost an entry without a transaction");

endmodule
